>>> hw/rtl/cbmt_pkg.sv
// Shared types and constants for the cache block map table.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package cbmt_pkg;

    localparam int BUCKETS_DEF = 1024;
    localparam int ENTRIES_DEF = 4096;

    localparam int VOL_W      = 32;
    localparam int FILE_W     = 64;
    localparam int BLK_W      = 64;
    localparam int OFF_W      = 64;
    localparam int KEY_W      = VOL_W + FILE_W + BLK_W;
    localparam int BSIZE_W    = 32;
    localparam int CSIZE_W    = 64;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;
    localparam int ALIGN_BITS = 12;   // blocks are multiples of 4096 bytes

    localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RST = BSIZE_W'(4096);

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_INSERT = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_REJECTED  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_BAD_SIZE  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_SIZE = 1'd1;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_CHECK,
        S_INS_RD,
        S_INS_WR,
        S_HEAD,
        S_LOAD,
        S_FETCH,
        S_CMP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [VOL_W-1:0]  vol;
        logic [FILE_W-1:0] file;
        logic [BLK_W-1:0]  blk;
        logic [OFF_W-1:0]  off;
    } entry_t;

    typedef struct packed {
        logic head;
        logic entry;
        logic link;
        logic free_stk;
    } mem_wen_t;

endpackage

`default_nettype wire

>>> hw/rtl/cbmt_if.sv
// Handshake channels of the cache block map table: requests, responses, config writes.
// Depends on cbmt_pkg for field widths.
`default_nettype none

interface cbmt_req_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   req_type;
    logic [cbmt_pkg::VOL_W-1:0]   volume_serial;
    logic [cbmt_pkg::FILE_W-1:0]  file_ident;
    logic [cbmt_pkg::BLK_W-1:0]   block_number;
    logic [cbmt_pkg::OFF_W-1:0]   offset_in;

    modport source (output valid, req_type, volume_serial, file_ident, block_number,
                    offset_in, input ready);
    modport sink   (input valid, req_type, volume_serial, file_ident, block_number,
                    offset_in, output ready);
endinterface

interface cbmt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [cbmt_pkg::STATUS_W-1:0] status;
    logic [cbmt_pkg::OFF_W-1:0]    offset_out;

    modport source (output valid, status, offset_out, input ready);
    modport sink   (input valid, status, offset_out, output ready);
endinterface

interface cbmt_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [cbmt_pkg::CFG_IDX_W-1:0]  index;
    logic [cbmt_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/cbmt_hash.sv
// Bucket hash: xor fold of the 160-bit key, reduced into the bucket range.
// Depends on cbmt_pkg.
`default_nettype none

module cbmt_hash #(
    parameter int BUCKETS = cbmt_pkg::BUCKETS_DEF,
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  wire logic [cbmt_pkg::VOL_W-1:0]  vol,
    input  wire logic [cbmt_pkg::FILE_W-1:0] file,
    input  wire logic [cbmt_pkg::BLK_W-1:0]  blk,
    output logic      [BW-1:0]               bucket
);
    import cbmt_pkg::*;

    logic [KEY_W-1:0] key;
    logic [BW-1:0]    fold;

    assign key = {vol, file, blk};

    always_comb
    begin
        fold = '0;
        for (int i = 0; i < KEY_W; i++)
        begin
            fold[i % BW] = fold[i % BW] ^ key[i];
        end
    end

    // fold < 2^BW < 2*BUCKETS, so one subtract brings it in range
    always_comb
    begin
        if ({1'b0, fold} >= (BW+1)'(BUCKETS))
            bucket = fold - BW'(BUCKETS);
        else
            bucket = fold;
    end

endmodule

`default_nettype wire

>>> hw/rtl/cbmt_store.sv
// Table storage: bucket heads, slot contents, slot links and the free slot stack.
// Single write and registered read per memory. Depends on cbmt_pkg.
`default_nettype none

module cbmt_store #(
    parameter int BUCKETS = cbmt_pkg::BUCKETS_DEF,
    parameter int ENTRIES = cbmt_pkg::ENTRIES_DEF,
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int LW = $clog2(ENTRIES + 1)
) (
    input  wire logic              clk,
    input  wire cbmt_pkg::mem_wen_t wen,
    input  wire logic [BW-1:0]     head_waddr,
    input  wire logic [LW-1:0]     head_wdata,
    input  wire logic [BW-1:0]     head_raddr,
    output logic      [LW-1:0]     head_rdata,
    input  wire logic [EW-1:0]     entry_waddr,
    input  wire cbmt_pkg::entry_t  entry_wdata,
    input  wire logic [EW-1:0]     entry_raddr,
    output cbmt_pkg::entry_t       entry_rdata,
    input  wire logic [EW-1:0]     link_waddr,
    input  wire logic [LW-1:0]     link_wdata,
    output logic      [LW-1:0]     link_rdata,
    input  wire logic [EW-1:0]     free_waddr,
    input  wire logic [EW-1:0]     free_wdata,
    input  wire logic [EW-1:0]     free_raddr,
    output logic      [EW-1:0]     free_rdata
);
    import cbmt_pkg::*;

    logic [LW-1:0] head_mem  [BUCKETS];
    entry_t        entry_mem [ENTRIES];
    logic [LW-1:0] link_mem  [ENTRIES];
    logic [EW-1:0] free_mem  [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wen.head)
            head_mem[head_waddr] <= head_wdata;
        head_rdata <= head_mem[head_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wen.entry)
            entry_mem[entry_waddr] <= entry_wdata;
        entry_rdata <= entry_mem[entry_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wen.link)
            link_mem[link_waddr] <= link_wdata;
        link_rdata <= link_mem[entry_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wen.free_stk)
            free_mem[free_waddr] <= free_wdata;
        free_rdata <= free_mem[free_raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/cbmt_ctrl.sv
// Request sequencer: config registers, insert checks, chain walk, free stack
// bookkeeping and the response register. Depends on cbmt_pkg and cbmt_if.
`default_nettype none

module cbmt_ctrl #(
    parameter int BUCKETS = cbmt_pkg::BUCKETS_DEF,
    parameter int ENTRIES = cbmt_pkg::ENTRIES_DEF,
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int LW = $clog2(ENTRIES + 1)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    cbmt_req_if.sink                req,
    cbmt_rsp_if.source              rsp,
    cbmt_cfg_if.sink                cfg,
    input  wire logic [BW-1:0]      bucket,
    output cbmt_pkg::mem_wen_t      wen,
    output logic      [BW-1:0]      head_waddr,
    output logic      [LW-1:0]      head_wdata,
    output logic      [BW-1:0]      head_raddr,
    input  wire logic [LW-1:0]      head_rdata,
    output logic      [EW-1:0]      entry_waddr,
    output cbmt_pkg::entry_t        entry_wdata,
    output logic      [EW-1:0]      entry_raddr,
    input  wire cbmt_pkg::entry_t   entry_rdata,
    output logic      [EW-1:0]      link_waddr,
    output logic      [LW-1:0]      link_wdata,
    input  wire logic [LW-1:0]      link_rdata,
    output logic      [EW-1:0]      free_waddr,
    output logic      [EW-1:0]      free_wdata,
    output logic      [EW-1:0]      free_raddr,
    input  wire logic [EW-1:0]      free_rdata
);
    import cbmt_pkg::*;

    localparam logic [LW-1:0] NO_SLOT = LW'(ENTRIES);

    state_t              state_reg, state_next;
    logic [1:0]          type_reg;
    entry_t              item_reg;
    logic [BW-1:0]       bkt_reg;
    logic [BW-1:0]       sweep_reg, sweep_next;
    logic                clr_rsp_reg, clr_rsp_next;
    logic [LW-1:0]       cur_reg, cur_next;
    logic [LW-1:0]       prev_reg, prev_next;
    logic [LW-1:0]       guard_reg, guard_next;
    logic [LW-1:0]       count_reg, count_next;
    logic [LW-1:0]       low_reg, low_next;
    logic                fresh_reg, fresh_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [OFF_W-1:0]    found_reg, found_next;
    logic [BSIZE_W-1:0]  bsize_reg;
    logic [CSIZE_W-1:0]  csize_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [OFF_W-1:0]    out_offset_reg;

    logic                accept;
    logic                out_free;
    logic                bad_size;
    logic                reject;
    logic [OFF_W:0]      range_end;
    logic                sweep_last;
    logic                key_hit;
    logic                walk_end;
    logic [LW-1:0]       count_dec;
    logic [EW-1:0]       new_slot;

    assign accept     = req.valid && req.ready;
    assign out_free   = !out_valid_reg || rsp.ready;
    assign bad_size   = (bsize_reg == '0) || (bsize_reg[ALIGN_BITS-1:0] != '0);
    assign range_end  = {1'b0, item_reg.off} + (OFF_W+1)'(bsize_reg);
    assign reject     = (range_end > {1'b0, csize_reg}) || (item_reg.file == '0);
    assign sweep_last = (sweep_reg == BW'(BUCKETS - 1));
    assign key_hit    = (entry_rdata.vol == item_reg.vol) && (entry_rdata.file == item_reg.file)
                        && (entry_rdata.blk == item_reg.blk);
    assign walk_end   = (cur_reg >= NO_SLOT) || (guard_reg == NO_SLOT);
    assign count_dec  = count_reg - LW'(1);
    // slots below the low-water mark were never pushed since the last clear
    assign new_slot   = fresh_reg ? count_reg[EW-1:0] : free_rdata;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_SWEEP:
                if (sweep_last)
                    state_next = clr_rsp_reg ? S_DONE : S_IDLE;
            S_IDLE:
                if (accept)
                begin
                    priority case (req.req_type)
                        REQ_CLEAR:  state_next = S_SWEEP;
                        REQ_INSERT: state_next = S_CHECK;
                        default:    state_next = S_HEAD;
                    endcase
                end
            S_CHECK:
                if (bad_size || reject || count_reg == '0)
                    state_next = S_DONE;
                else
                    state_next = S_INS_RD;
            S_INS_RD: state_next = S_INS_WR;
            S_INS_WR: state_next = S_DONE;
            S_HEAD:   state_next = S_LOAD;
            S_LOAD:   state_next = S_FETCH;
            S_FETCH:  state_next = walk_end ? S_DONE : S_CMP;
            S_CMP:    state_next = key_hit ? S_DONE : S_FETCH;
            S_DONE:
                if (out_free)
                    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // memory controls and handshake
    always_comb
    begin
        wen         = '0;
        head_waddr  = bkt_reg;
        head_wdata  = NO_SLOT;
        head_raddr  = bkt_reg;
        entry_waddr = new_slot;
        entry_wdata = item_reg;
        entry_raddr = cur_reg[EW-1:0];
        link_waddr  = new_slot;
        link_wdata  = head_rdata;
        free_waddr  = count_reg[EW-1:0];
        free_wdata  = cur_reg[EW-1:0];
        // top of stack once the count has been decremented in S_CHECK
        free_raddr  = count_reg[EW-1:0];
        unique case (state_reg)
            S_SWEEP:
            begin
                wen.head   = 1'b1;
                head_waddr = sweep_reg;
            end
            S_INS_WR:
            begin
                wen.head   = 1'b1;
                wen.entry  = 1'b1;
                wen.link   = 1'b1;
                head_wdata = LW'(new_slot);
            end
            S_CMP:
                if (key_hit && type_reg == REQ_REMOVE)
                begin
                    // unlink from head or from the previous slot
                    wen.head     = (prev_reg == NO_SLOT);
                    wen.link     = (prev_reg != NO_SLOT);
                    head_wdata   = link_rdata;
                    link_waddr   = prev_reg[EW-1:0];
                    link_wdata   = link_rdata;
                    wen.free_stk = (count_reg < NO_SLOT);
                end
            default: ;
        endcase
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign cfg.ready      = 1'b1;
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.offset_out = out_offset_reg;

    // datapath next values
    always_comb
    begin
        sweep_next   = sweep_reg;
        clr_rsp_next = clr_rsp_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        guard_next   = guard_reg;
        count_next   = count_reg;
        low_next     = low_reg;
        fresh_next   = fresh_reg;
        status_next  = status_reg;
        found_next   = found_reg;
        unique case (state_reg)
            S_SWEEP:
                sweep_next = sweep_reg + BW'(1);
            S_IDLE:
            begin
                status_next = STAT_OK;
                found_next  = '0;
                if (accept && req.req_type == REQ_CLEAR)
                begin
                    sweep_next   = '0;
                    clr_rsp_next = 1'b1;
                    count_next   = NO_SLOT;
                    low_next     = NO_SLOT;
                end
            end
            S_CHECK:
                priority if (bad_size)
                    status_next = STAT_BAD_SIZE;
                else if (reject)
                    status_next = STAT_REJECTED;
                else if (count_reg == '0)
                    status_next = STAT_FULL;
                else
                begin
                    fresh_next = (count_dec < low_reg);
                    count_next = count_dec;
                    if (count_dec < low_reg)
                        low_next = count_dec;
                end
            S_LOAD:
            begin
                cur_next    = head_rdata;
                prev_next   = NO_SLOT;
                guard_next  = '0;
                status_next = STAT_NOT_FOUND;
            end
            S_CMP:
                if (key_hit)
                begin
                    status_next = STAT_OK;
                    if (type_reg == REQ_LOOKUP)
                        found_next = entry_rdata.off;
                    else if (count_reg < NO_SLOT)
                        count_next = count_reg + LW'(1);
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = link_rdata;
                    guard_next = guard_reg + LW'(1);
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_SWEEP;
            sweep_reg   <= '0;
            clr_rsp_reg <= 1'b0;
            count_reg   <= NO_SLOT;
            low_reg     <= NO_SLOT;
        end
        else
        begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            clr_rsp_reg <= clr_rsp_next;
            count_reg   <= count_next;
            low_reg     <= low_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        guard_reg  <= guard_next;
        fresh_reg  <= fresh_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        if (accept)
        begin
            type_reg      <= req.req_type;
            item_reg.vol  <= req.volume_serial;
            item_reg.file <= req.file_ident;
            item_reg.blk  <= req.block_number;
            item_reg.off  <= req.offset_in;
            bkt_reg       <= bucket;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsize_reg <= BLOCK_SIZE_RST;
            csize_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_BLOCK_SIZE: bsize_reg <= cfg.data[BSIZE_W-1:0];
                CFG_CACHE_SIZE: csize_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // response register; loaded only once the previous transfer is gone
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == S_DONE && out_free)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            out_status_reg <= status_reg;
            out_offset_reg <= found_reg;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/cache_block_map_table_core.sv
// Cache block map table: hashed key to cache offset map, top level.
// Depends on cbmt_pkg, cbmt_if, cbmt_hash, cbmt_store and cbmt_ctrl.
//
// Channels: req (lookup, remove, insert, clear), rsp (one status/offset per
// request), cfg (writes of block_size at index 0 and cache_size at index 1;
// always ready; the user must see that it is written only while the block is
// idle, which the block itself does not enforce). One request at a time:
// req.ready is high only while the sequencer is idle. Request steps, limited
// by the registered reads of the table memories, each ending in the response:
//   insert: check, free stack read, slot and head write, unless a check fails
//   lookup/remove: head read, load, then fetch and compare per chain slot
//   clear: one bucket head written per cycle
// Reset: rst_n resets the sequencer and the free stack count, sets block_size
// to 4096 and cache_size to 0, then a sweep empties every bucket head before
// req.ready rises.
// Stall: a finished response waits in the rsp register; the next request is
// accepted meanwhile, and a later response waits in the sequencer until the
// rsp register has been taken.
`default_nettype none

module cache_block_map_table_core #(
    parameter int BUCKETS = cbmt_pkg::BUCKETS_DEF,
    parameter int ENTRIES = cbmt_pkg::ENTRIES_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cbmt_req_if.sink   req,
    cbmt_rsp_if.source rsp,
    cbmt_cfg_if.sink   cfg
);
    import cbmt_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LW = $clog2(ENTRIES + 1);

    logic [BW-1:0] bucket;
    mem_wen_t      wen;
    logic [BW-1:0] head_waddr, head_raddr;
    logic [LW-1:0] head_wdata, head_rdata;
    logic [EW-1:0] entry_waddr, entry_raddr;
    entry_t        entry_wdata, entry_rdata;
    logic [EW-1:0] link_waddr;
    logic [LW-1:0] link_wdata, link_rdata;
    logic [EW-1:0] free_waddr, free_wdata, free_raddr, free_rdata;

    cbmt_hash #(.BUCKETS(BUCKETS)) u_hash (
        .vol    (req.volume_serial),
        .file   (req.file_ident),
        .blk    (req.block_number),
        .bucket (bucket)
    );

    cbmt_store #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_store (
        .clk         (clk),
        .wen         (wen),
        .head_waddr  (head_waddr),
        .head_wdata  (head_wdata),
        .head_raddr  (head_raddr),
        .head_rdata  (head_rdata),
        .entry_waddr (entry_waddr),
        .entry_wdata (entry_wdata),
        .entry_raddr (entry_raddr),
        .entry_rdata (entry_rdata),
        .link_waddr  (link_waddr),
        .link_wdata  (link_wdata),
        .link_rdata  (link_rdata),
        .free_waddr  (free_waddr),
        .free_wdata  (free_wdata),
        .free_raddr  (free_raddr),
        .free_rdata  (free_rdata)
    );

    cbmt_ctrl #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg         (cfg),
        .bucket      (bucket),
        .wen         (wen),
        .head_waddr  (head_waddr),
        .head_wdata  (head_wdata),
        .head_raddr  (head_raddr),
        .head_rdata  (head_rdata),
        .entry_waddr (entry_waddr),
        .entry_wdata (entry_wdata),
        .entry_raddr (entry_raddr),
        .entry_rdata (entry_rdata),
        .link_waddr  (link_waddr),
        .link_wdata  (link_wdata),
        .link_rdata  (link_rdata),
        .free_waddr  (free_waddr),
        .free_wdata  (free_wdata),
        .free_raddr  (free_raddr),
        .free_rdata  (free_rdata)
    );

endmodule

`default_nettype wire

>>> tb/tb_cache_block_map_table_core.sv
// Testbench for cache_block_map_table_core: directed table, then random traffic.
// Depends on cbmt_pkg and cbmt_if; checks each response against a directed row or the map model.
`timescale 1ns / 100ps

module tb_cache_block_map_table_core;
    import cbmt_pkg::*;

    localparam int NBKT   = BUCKETS_DEF;
    localparam int NSLOT  = ENTRIES_DEF;
    localparam int WD_MAX = 60000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        bit [1:0]  kind;
        bit [31:0] vol;
        bit [63:0] file;
        bit [63:0] blk;
        bit [63:0] off;
    } map_req_t;

    typedef struct packed {
        bit [2:0]  st;
        bit [63:0] off;
    } map_rsp_t;

    typedef struct packed {
        map_req_t  rq;
        bit        typed;
        map_rsp_t  rs;
    } dir_row_t;

    typedef struct packed {
        bit [31:0] vol;
        bit [63:0] file;
        bit [63:0] blk;
    } map_key_t;

    logic clk;
    logic rst_n;

    cbmt_req_if req();
    cbmt_rsp_if rsp();
    cbmt_cfg_if cfg();

    cache_block_map_table_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // map model state
    bit [31:0] m_bsize;
    bit [63:0] m_csize;
    int        m_head  [NBKT];
    bit [31:0] m_vol   [NSLOT];
    bit [63:0] m_file  [NSLOT];
    bit [63:0] m_blk   [NSLOT];
    bit [63:0] m_off   [NSLOT];
    int        m_link  [NSLOT];
    int        m_free  [NSLOT];
    int        m_nfree;

    map_rsp_t  pending_rsp[$];
    map_key_t  key_pool[$];
    int        errors;
    int        n_req;
    int        n_rsp;
    int        n_hits;
    int        n_full;
    int        idle_cnt;
    bit        idle_en;
    bit        hold_req;

    initial begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic int bucket_of(bit [31:0] v, bit [63:0] f, bit [63:0] b);
        bit [63:0] x;
        x = 64'(v) * 64'hC2B2AE3D27D4EB4F;
        x ^= f;
        x = (x ^ (x >> 31)) * 64'h9E3779B97F4A7C15;
        x ^= b;
        x = (x ^ (x >> 29)) * 64'hBF58476D1CE4E5B9;
        x ^= x >> 32;
        return int'(x[9:0]);
    endfunction

    function automatic void map_clear();
        for (int i = 0; i < NBKT; i++)
            m_head[i] = NSLOT;
        for (int i = 0; i < NSLOT; i++)
            m_free[i] = i;
        m_nfree = NSLOT;
    endfunction

    function automatic map_rsp_t map_apply(map_req_t r);
        map_rsp_t  res;
        bit [64:0] fin;
        int        b;
        int        s;
        int        prv;
        int        cur;
        res = '0;
        if (r.kind == REQ_CLEAR) begin
            map_clear();
        end else if (r.kind == REQ_INSERT) begin
            fin = {1'b0, r.off} + 65'(m_bsize);
            if (m_bsize == 0 || m_bsize[ALIGN_BITS-1:0] != 0)
                res.st = STAT_BAD_SIZE;
            else if (fin > {1'b0, m_csize} || r.file == 0)
                res.st = STAT_REJECTED;
            else if (m_nfree == 0)
                res.st = STAT_FULL;
            else begin
                b = bucket_of(r.vol, r.file, r.blk);
                m_nfree--;
                s = m_free[m_nfree];
                m_vol[s]  = r.vol;
                m_file[s] = r.file;
                m_blk[s]  = r.blk;
                m_off[s]  = r.off;
                m_link[s] = m_head[b];
                m_head[b] = s;
                res.st = STAT_OK;
            end
        end else begin
            b = bucket_of(r.vol, r.file, r.blk);
            prv = NSLOT;
            cur = m_head[b];
            res.st = STAT_NOT_FOUND;
            while (cur < NSLOT) begin
                if (m_vol[cur] == r.vol && m_file[cur] == r.file && m_blk[cur] == r.blk) begin
                    if (r.kind == REQ_LOOKUP)
                        res.off = m_off[cur];
                    else begin
                        if (prv == NSLOT)
                            m_head[b] = m_link[cur];
                        else
                            m_link[prv] = m_link[cur];
                        m_free[m_nfree] = cur;
                        m_nfree++;
                    end
                    res.st = STAT_OK;
                    break;
                end
                prv = cur;
                cur = m_link[cur];
            end
        end
        return res;
    endfunction

    task automatic report(string what, bit [63:0] want, bit [63:0] got);
        $display("MISMATCH rsp #%0d %s: expected 0x%0h got 0x%0h", n_rsp, what, want, got);
        errors++;
    endtask

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send(map_req_t r, bit typed, map_rsp_t want);
        map_rsp_t guess;
        @(negedge clk);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        req.valid         <= 1'b1;
        req.req_type      <= r.kind;
        req.volume_serial <= r.vol;
        req.file_ident    <= r.file;
        req.block_number  <= r.blk;
        req.offset_in     <= r.off;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        guess = map_apply(r);
        pending_rsp.push_back(typed ? want : guess);
        n_req++;
    endtask

    task automatic drain();
        // drop the last request before the sequencer comes back to idle
        @(negedge clk);
        req.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(bit [CFG_IDX_W-1:0] idx, bit [63:0] val);
        @(negedge clk);
        req.valid  <= 1'b0;
        cfg.valid  <= 1'b1;
        cfg.index  <= idx;
        cfg.data   <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        if (idx == CFG_BLOCK_SIZE)
            m_bsize = val[31:0];
        else
            m_csize = val;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic set_sizes(bit [31:0] bs, bit [63:0] cs);
        drain();
        cfg_write(CFG_BLOCK_SIZE, {32'h0, bs});
        cfg_write(CFG_CACHE_SIZE, cs);
    endtask

    function automatic map_req_t rand_req();
        map_req_t  r;
        map_key_t  k;
        bit [64:0] span;
        int        p;
        p = $urandom_range(0, 99);
        r.kind = p < 3 ? REQ_CLEAR : p < 40 ? REQ_INSERT : p < 75 ? REQ_LOOKUP : REQ_REMOVE;
        if ($urandom_range(0, 99) < 85)
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else
            k = {$urandom, rand64(), rand64()};
        r.vol  = k.vol;
        r.file = k.file;
        r.blk  = k.blk;
        span = {1'b0, m_csize} - 65'(m_bsize) + 65'd1;
        if (r.kind != REQ_INSERT || $urandom_range(0, 9) == 0 || span[64] || span == 0)
            r.off = rand64();
        else
            r.off = 64'(65'(rand64()) % span);
        return r;
    endfunction

    task automatic random_phase(int count);
        map_rsp_t nil;
        nil = '0;
        for (int i = 0; i < count; i++)
            send(rand_req(), 1'b0, nil);
    endtask

    // response checker and watchdog
    always @(posedge clk) begin
        map_rsp_t w;
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WD_MAX) begin
            $display("watchdog: no transfer for %0d cycles", WD_MAX);
            $display("TEST FAILED");
            $finish;
        end
        if (rst_n && rsp.valid && rsp.ready) begin
            if (pending_rsp.size() == 0) begin
                $display("unexpected response: status %0d offset 0x%0h", rsp.status,
                         rsp.offset_out);
                errors++;
            end else begin
                w = pending_rsp.pop_front();
                if (rsp.status !== w.st)
                    report("status", 64'(w.st), 64'(rsp.status));
                if (rsp.offset_out !== w.off)
                    report("offset_out", w.off, rsp.offset_out);
                if (w.st == STAT_OK && w.off != 0)
                    n_hits++;
                if (w.st == STAT_FULL)
                    n_full++;
            end
            n_rsp++;
        end
    end

    // response side: random back-pressure, one long hold-off on request
    initial begin
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req) begin
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
            end
            rsp.ready <= 1'b1;
        end
    end

    initial begin
        dir_row_t  rows[$];
        map_key_t  ka;
        map_key_t  kz;
        map_rsp_t  nil;
        bit [63:0] top;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.req_type = REQ_LOOKUP;
        req.volume_serial = '0;
        req.file_ident = '0;
        req.block_number = '0;
        req.offset_in = '0;
        cfg.valid = 1'b0;
        cfg.index = CFG_BLOCK_SIZE;
        cfg.data = '0;
        errors = 0;
        n_req = 0;
        n_rsp = 0;
        n_hits = 0;
        n_full = 0;
        idle_cnt = 0;
        idle_en = 1'b1;
        hold_req = 1'b0;
        nil = '0;
        m_bsize = BLOCK_SIZE_RST;
        m_csize = '0;
        map_clear();
        for (int i = 0; i < 48; i++)
            key_pool.push_back({$urandom, (i % 12 == 0) ? 64'h0 : rand64(),
                                (i % 2) ? rand64() : 64'($urandom_range(0, 7))});
        ka = {32'h1234_5678, 64'h1, 64'h0};
        kz = {32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
        top = 64'hFFFF_FFFF_FFFF_E000;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset registers: cache size zero rejects every insert
        rows = '{
            '{'{REQ_LOOKUP, ka.vol, ka.file, ka.blk, 64'h0}, 1'b1, '{STAT_NOT_FOUND, 64'h0}},
            '{'{REQ_REMOVE, kz.vol, kz.file, kz.blk, 64'h0}, 1'b1, '{STAT_NOT_FOUND, 64'h0}},
            '{'{REQ_INSERT, ka.vol, ka.file, ka.blk, 64'h0}, 1'b1, '{STAT_REJECTED, 64'h0}},
            '{'{REQ_CLEAR, 32'h0, 64'h0, 64'h0, 64'h0}, 1'b1, '{STAT_OK, 64'h0}}
        };
        foreach (rows[i])
            send(rows[i].rq, rows[i].typed, rows[i].rs);

        // whole 64-bit cache; newest entry shadows an older one with the same key
        set_sizes(32'd4096, 64'hFFFF_FFFF_FFFF_FFFF);
        rows = '{
            '{'{REQ_INSERT, ka.vol, ka.file, ka.blk, 64'h0}, 1'b1, '{STAT_OK, 64'h0}},
            '{'{REQ_INSERT, ka.vol, ka.file, ka.blk, 64'hFFFF_FFFF_FFFF_F000}, 1'b1,
              '{STAT_REJECTED, 64'h0}},
            '{'{REQ_INSERT, ka.vol, ka.file, ka.blk, top}, 1'b1, '{STAT_OK, 64'h0}},
            '{'{REQ_LOOKUP, ka.vol, ka.file, ka.blk, 64'h0}, 1'b1, '{STAT_OK, top}},
            '{'{REQ_REMOVE, ka.vol, ka.file, ka.blk, 64'h0}, 1'b1, '{STAT_OK, 64'h0}},
            '{'{REQ_LOOKUP, ka.vol, ka.file, ka.blk, 64'h0}, 1'b1, '{STAT_OK, 64'h0}},
            '{'{REQ_INSERT, 32'h0, 64'h0, 64'h5, 64'h0}, 1'b1, '{STAT_REJECTED, 64'h0}},
            '{'{REQ_INSERT, kz.vol, kz.file, kz.blk, 64'h5555_AAAA_0F0F_F0F0}, 1'b0, nil},
            '{'{REQ_LOOKUP, kz.vol, kz.file, kz.blk, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, nil},
            '{'{REQ_REMOVE, ka.vol, ka.file, ka.blk, 64'h0}, 1'b1, '{STAT_OK, 64'h0}},
            '{'{REQ_REMOVE, ka.vol, ka.file, ka.blk, 64'h0}, 1'b1, '{STAT_NOT_FOUND, 64'h0}},
            '{'{REQ_CLEAR, 32'h0, 64'h0, 64'h0, 64'h0}, 1'b1, '{STAT_OK, 64'h0}},
            '{'{REQ_LOOKUP, kz.vol, kz.file, kz.blk, 64'h0}, 1'b1, '{STAT_NOT_FOUND, 64'h0}}
        };
        foreach (rows[i])
            send(rows[i].rq, rows[i].typed, rows[i].rs);

        // bad block sizes win over every other check; clear ignores them
        set_sizes(32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send('{REQ_INSERT, ka.vol, ka.file, ka.blk, 64'h0}, 1'b1, '{STAT_BAD_SIZE, 64'h0});
        set_sizes(32'd4097, 64'h0);
        send('{REQ_INSERT, ka.vol, 64'h0, ka.blk, 64'h0}, 1'b1, '{STAT_BAD_SIZE, 64'h0});
        set_sizes(32'hFFFF_FFFF, 64'h0);
        send('{REQ_INSERT, ka.vol, ka.file, ka.blk, 64'h0}, 1'b1, '{STAT_BAD_SIZE, 64'h0});
        send('{REQ_CLEAR, 32'h0, 64'h0, 64'h0, 64'h0}, 1'b1, '{STAT_OK, 64'h0});

        // random traffic over several register settings
        set_sizes(32'd4096, 64'h100_0000_0000);
        random_phase(150);
        hold_req = 1'b1;
        random_phase(150);
        set_sizes(32'hFFFF_F000, 64'hFFFF_FFFF_FFFF_FFFF);
        random_phase(300);
        set_sizes(32'd8192, 64'h10_0000);
        random_phase(250);
        set_sizes(32'd12288, 64'hFFFF_FFFF_FFFF_FFFF);
        random_phase(200);
        idle_en = 1'b0;
        random_phase(200);

        @(negedge clk);
        req.valid <= 1'b0;
        drain();
        repeat (20) @(posedge clk);
        $display("covered %0d requests, %0d responses: directed extremes, shadowed keys, %0d lookup hits",
                 n_req, n_rsp, n_hits);
        $display("register settings swept incl. zero/unaligned block size; %0d full replies",
                 n_full);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/cbmt_pkg.sv
hw/rtl/cbmt_if.sv
hw/rtl/cbmt_hash.sv
hw/rtl/cbmt_store.sv
hw/rtl/cbmt_ctrl.sv
hw/rtl/cache_block_map_table_core.sv
tb/tb_cache_block_map_table_core.sv
